[hw/rtl/nlc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared types and constants for the next lexicographic combination block.
// ----------------------------------------------------------------------------
package nlc_pkg;

  localparam int unsigned MAX_K_DEF = 16;

  localparam int unsigned ELEM_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  out_position;
    logic [ELEM_W-1:0] out_value;
    logic              found;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] max_value;
    logic [SIZE_W-1:0] subset_size;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FILL,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EXHAUST
  } state_e;

endpackage

[hw/rtl/nlc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/nlc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_ctrl
// Sequencer that searches, refills and streams the combination held in RAM.
// ----------------------------------------------------------------------------
module nlc_ctrl #(
  parameter int unsigned MaxK = nlc_pkg::MAX_K_DEF,
  localparam int unsigned AddrW = (MaxK > 1) ? $clog2(MaxK) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nlc_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nlc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nlc_pkg::out_item_t out_data_o,
  output logic               mem_we_o,
  output logic [AddrW-1:0]   mem_waddr_o,
  output logic [7:0]         mem_wdata_o,
  output logic               mem_re_o,
  output logic [AddrW-1:0]   mem_raddr_o,
  input  logic [7:0]         mem_rdata_i
);
  import nlc_pkg::*;

  localparam int unsigned KW = $clog2(MaxK + 1);

  state_e            state_q, state_d;
  logic [KW-1:0]     idx_q, idx_d;
  logic [7:0]        run_q, run_d;
  logic [MaxK-1:0]   valid_q, valid_d;
  logic              rd_valid_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic [KW-1:0]     k_eff;
  logic [7:0]        rd_val;
  logic              grow;
  logic              out_free;
  logic              is_last;
  logic [9:0]        lhs;
  logic [9:0]        rhs;

  always_comb begin
    if (int'(cfg_i.subset_size) > MaxK) begin
      k_eff = KW'(MaxK);
    end else begin
      k_eff = KW'(cfg_i.subset_size);
    end
  end

  assign rd_val   = rd_valid_q ? mem_rdata_i : '0;
  assign lhs      = 10'(rd_val) + 10'(k_eff);
  assign rhs      = 10'(cfg_i.max_value) + 10'd1 + 10'(idx_q);
  assign grow     = lhs < rhs;
  assign out_free = !out_valid_q || out_ready_i;
  assign is_last  = idx_q == KW'(k_eff - 1'b1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_data_i.kind == KIND_ADVANCE) begin
          state_d = (k_eff == '0) ? ST_EXHAUST : ST_SRCH_RD;
        end
      end
      ST_SRCH_RD:  state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (grow) begin
          state_d = ST_FILL;
        end else if (idx_q == '0) begin
          state_d = ST_EXHAUST;
        end else begin
          state_d = ST_SRCH_RD;
        end
      end
      ST_FILL: begin
        if (idx_q == k_eff) begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD:  state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free) begin
          state_d = is_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EXHAUST: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    run_d       = run_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AddrW-1:0];
    mem_wdata_o = run_q + 8'd1;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AddrW-1:0];
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_ADVANCE) begin
            idx_d = KW'(k_eff - 1'b1);
          end else if (int'(in_data_i.position) < MaxK) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AddrW'(in_data_i.position);
            mem_wdata_o = in_data_i.value;
          end
        end
      end
      ST_SRCH_RD: begin
        mem_re_o = 1'b1;
      end
      ST_SRCH_CMP: begin
        if (grow) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = rd_val + 8'd1;
          run_d       = rd_val + 8'd1;
          idx_d       = idx_q + 1'b1;
        end else if (idx_q != '0) begin
          idx_d = idx_q - 1'b1;
        end
      end
      ST_FILL: begin
        if (idx_q == k_eff) begin
          idx_d = '0;
        end else begin
          mem_we_o = 1'b1;
          run_d    = run_q + 8'd1;
          idx_d    = idx_q + 1'b1;
        end
      end
      ST_EMIT_RD: begin
        mem_re_o = 1'b1;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.out_position = POS_W'(idx_q);
          out_data_d.out_value    = rd_val;
          out_data_d.found        = 1'b1;
          out_data_d.last         = is_last;
          idx_d                   = idx_q + 1'b1;
        end
      end
      ST_EXHAUST: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.out_position = '0;
          out_data_d.out_value    = '0;
          out_data_d.found        = 1'b0;
          out_data_d.last         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (mem_we_o) begin
      valid_d[mem_waddr_o] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (mem_re_o) begin
        rd_valid_q <= valid_q[mem_raddr_o];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hw/rtl/next_lexicographic_combination.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_lexicographic_combination
// Steps a stored k-combination of 1..n to its lexicographic successor.
// ----------------------------------------------------------------------------
// The combination lives in a MaxK-entry RAM with a registered read, and each
// entry reads as zero until it is first written. A load item writes its entry
// directly. An advance item reads entries from the right, one RAM read and one
// compare per position examined, until it finds the pivot p; it then writes
// the k-1-p refilled entries at one per cycle and streams the k elements out,
// each as a RAM read followed by the output register load. An exhausted
// advance gives a single result. Output stalls hold the result stream. The
// next item is taken once the last result sits in the output register.
module next_lexicographic_combination #(
  parameter int unsigned MaxK = nlc_pkg::MAX_K_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nlc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nlc_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  nlc_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output nlc_pkg::out_item_t               out_data_o
);
  import nlc_pkg::*;

  localparam int unsigned AddrW = (MaxK > 1) ? $clog2(MaxK) : 1;

  logic [ELEM_W-1:0] max_value_q;
  logic [SIZE_W-1:0] subset_size_q;
  cfg_t              cfg;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [7:0]        mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q   <= ELEM_W'(1);
      subset_size_q <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_VALUE:   max_value_q   <= cfg_wdata_i;
        CFG_SUBSET_SIZE: subset_size_q <= cfg_wdata_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.max_value   = max_value_q;
  assign cfg.subset_size = subset_size_q;

  nlc_ctrl #(
    .MaxK(MaxK)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  nlc_ram #(
    .Width(ELEM_W),
    .Depth(MaxK)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[hw/rtl/nlc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_checker
// Port-level checks for the next lexicographic combination block.
// ----------------------------------------------------------------------------
module nlc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input nlc_pkg::out_item_t out_data_o
);

  // A result waiting for transfer must hold its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // An exhausted advance produces one result, which must be marked last.
  a_exhaust_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.last)
    else $error("exhausted result not marked last");

  // The exhausted result carries zero position and value.
  a_exhaust_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found
      |-> out_data_o.out_position == '0 && out_data_o.out_value == '0)
    else $error("exhausted result has nonzero fields");

  // No new item is taken while an advance still has results to produce.
  a_busy_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input accepted in the middle of a result stream");

endmodule

bind next_lexicographic_combination nlc_checker u_nlc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[verif/next_lexicographic_combination_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_lexicographic_combination_checker
// Scoreboard for the next lexicographic combination block.
// ----------------------------------------------------------------------------
// Follows the register writes and keeps its own copy of the stored
// combination. Each advance transfer on the input channel produces the list of
// elements the block has to return. Each output transfer is compared field by
// field with the oldest of those elements. Mismatches and unexpected elements
// are counted, and the count of elements still owed is reported to the top.
// ----------------------------------------------------------------------------
module next_lexicographic_combination_checker #(
  parameter int unsigned MaxK = nlc_pkg::MAX_K_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nlc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nlc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  nlc_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  nlc_pkg::out_item_t            out_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import nlc_pkg::*;

  localparam int unsigned ReportLimit = 10;

  logic [ELEM_W-1:0] comb_q [MaxK];
  logic [ELEM_W-1:0] max_value_q;
  logic [SIZE_W-1:0] subset_size_q;
  out_item_t         expected_elems [$];
  int                mismatch_count;

  task automatic advance_combination();
    int        k;
    int        n;
    int        pivot;
    int        i;
    out_item_t elem;
    k = (int'(subset_size_q) > int'(MaxK)) ? int'(MaxK) : int'(subset_size_q);
    n = int'(max_value_q);
    pivot = -1;
    i = k - 1;
    while (i >= 0 && pivot < 0) begin
      if (int'(comb_q[i]) < n - k + 1 + i) begin
        pivot = i;
      end
      i--;
    end
    if (pivot < 0) begin
      elem.out_position = '0;
      elem.out_value    = '0;
      elem.found        = 1'b0;
      elem.last         = 1'b1;
      expected_elems.push_back(elem);
    end else begin
      comb_q[pivot] = comb_q[pivot] + 1'b1;
      for (i = pivot + 1; i < k; i++) begin
        comb_q[i] = comb_q[i-1] + 1'b1;
      end
      for (i = 0; i < k; i++) begin
        elem.out_position = POS_W'(i);
        elem.out_value    = comb_q[i];
        elem.found        = 1'b1;
        elem.last         = (i == k - 1);
        expected_elems.push_back(elem);
      end
    end
  endtask

  task automatic check_elem(input out_item_t got);
    out_item_t want;
    if (expected_elems.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
        $display("%0t: unexpected element pos %0d val %0d found %0b last %0b", $realtime,
                 got.out_position, got.out_value, got.found, got.last);
      end
    end else begin
      want = expected_elems.pop_front();
      if (got.out_position !== want.out_position || got.out_value !== want.out_value ||
          got.found !== want.found || got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("%0t: element mismatch, expected pos %0d val %0d found %0b last %0b,",
                   $realtime, want.out_position, want.out_value, want.found, want.last);
          $display("    got pos %0d val %0d found %0b last %0b",
                   got.out_position, got.out_value, got.found, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MaxK); i++) begin
        comb_q[i] = '0;
      end
      max_value_q    = 8'd1;
      subset_size_q  = 5'd1;
      mismatch_count = 0;
      expected_elems.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAX_VALUE) begin
          max_value_q = cfg_wdata_i;
        end else if (cfg_index_i == CFG_SUBSET_SIZE) begin
          subset_size_q = cfg_wdata_i[SIZE_W-1:0];
        end
      end
      // Results are compared first so that a stray one never meets an
      // element queued by the input transfer of the same edge.
      if (out_valid_i && out_ready_i) begin
        check_elem(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KIND_LOAD) begin
          if (int'(in_data_i.position) < int'(MaxK)) begin
            comb_q[in_data_i.position] = in_data_i.value;
          end
        end else begin
          advance_combination();
        end
      end
    end
    fail_count_o = mismatch_count;
    pending_o    = expected_elems.size();
  end

endmodule

[verif/next_lexicographic_combination_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_lexicographic_combination_tb
// Top-level testbench for the next lexicographic combination block.
// ----------------------------------------------------------------------------
// Drives load and advance transfers with random gaps and random output stalls,
// including one long output stall that backs up the input channel. A short
// directed sequence covers the reset state, field extremes, a zero and an
// oversized subset size, a zero max value, a subset larger than the set and
// exhaustion. Random phases then change both registers while the block is
// idle and mostly load valid combinations followed by advances, with some
// phases of arbitrary loads and advances. The checker module predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module next_lexicographic_combination_tb;
  import nlc_pkg::*;

  localparam int unsigned MaxK        = MAX_K_DEF;
  localparam int unsigned ItemTarget  = 330;
  localparam int unsigned IdleSettle  = 8;
  localparam int unsigned DrainSettle = 80;
  localparam int unsigned HoldAfter   = 80;
  localparam int unsigned HoldCycles  = 300;
  localparam longint unsigned LimitNs = 64'd10_000_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;

  int fail_count;
  int pending;
  int items_sent;
  int results_taken;
  bit tx_steady;
  bit rx_steady;

  next_lexicographic_combination #(
    .MaxK(MaxK)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  next_lexicographic_combination_checker #(
    .MaxK(MaxK)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(LimitNs);
    $display("next_lexicographic_combination_tb NOT OK");
    $finish;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(15, 30);
  endfunction

  function automatic in_item_t make_load(input int pos, input int val);
    in_item_t item;
    item.kind     = KIND_LOAD;
    item.position = POS_W'(pos);
    item.value    = ELEM_W'(val);
    return item;
  endfunction

  function automatic in_item_t make_advance();
    in_item_t item;
    item.kind     = KIND_ADVANCE;
    item.position = POS_W'($urandom_range(0, 15));
    item.value    = ELEM_W'($urandom_range(0, 255));
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    gap = pick_gap(tx_steady);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // A load gives no result, so a settling wait (IdleSettle) follows the last
  // element before the block is treated as idle.
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (IdleSettle) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input int data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= CFG_W'(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Output side: random stalls, plus one long hold-off while the sender keeps
  // offering transfers.
  initial begin
    int  gap;
    bit  hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_taken >= HoldAfter) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      gap = pick_gap(rx_steady);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      results_taken++;
    end
  end

  initial begin
    int sel;
    int n_cfg;
    int k_cfg;
    int keff;
    int lo;
    int need;
    int pos;
    int v;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_MAX_VALUE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    items_sent    = 0;
    results_taken = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: the first advance grows the zero element, the second
    // finds nothing left.
    send_item(make_advance());
    send_item(make_advance());

    settle_idle();
    cfg_write(CFG_MAX_VALUE, 255);
    cfg_write(CFG_SUBSET_SIZE, 16);
    send_item(make_load(15, 255));
    send_item(make_load(0, 0));
    send_item(make_load(7, 8'hAA));
    send_item(make_load(10, 8'h55));
    send_item(make_advance());
    send_item(make_advance());

    settle_idle();
    cfg_write(CFG_SUBSET_SIZE, 0);
    send_item(make_advance());

    settle_idle();
    cfg_write(CFG_SUBSET_SIZE, 31);
    send_item(make_advance());

    settle_idle();
    cfg_write(CFG_MAX_VALUE, 0);
    cfg_write(CFG_SUBSET_SIZE, 3);
    send_item(make_advance());

    settle_idle();
    cfg_write(CFG_MAX_VALUE, 2);
    cfg_write(CFG_SUBSET_SIZE, 5);
    send_item(make_advance());

    settle_idle();
    cfg_write(CFG_MAX_VALUE, 5);
    cfg_write(CFG_SUBSET_SIZE, 3);
    send_item(make_load(0, 3));
    send_item(make_load(1, 4));
    send_item(make_load(2, 5));
    send_item(make_advance());
    send_item(make_load(0, 1));
    send_item(make_load(1, 2));
    send_item(make_load(2, 3));
    send_item(make_advance());

    while (items_sent < ItemTarget) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        k_cfg = 0;
        n_cfg = $urandom_range(0, 255);
      end else if (sel == 1) begin
        k_cfg = $urandom_range(17, 31);
        n_cfg = $urandom_range(16, 255);
      end else if (sel == 2) begin
        k_cfg = $urandom_range(1, 16);
        n_cfg = $urandom_range(0, 3);
      end else if (sel < 6) begin
        k_cfg = $urandom_range(1, 16);
        n_cfg = 255 - $urandom_range(0, 3);
      end else begin
        k_cfg = (sel < 14) ? $urandom_range(1, 8) : $urandom_range(1, 16);
        n_cfg = k_cfg + $urandom_range(0, 6);
      end

      settle_idle();
      cfg_write(CFG_MAX_VALUE, n_cfg);
      cfg_write(CFG_SUBSET_SIZE, k_cfg);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      keff = (k_cfg > int'(MaxK)) ? int'(MaxK) : k_cfg;

      if ($urandom_range(0, 3) != 0 && keff >= 1 && keff <= n_cfg) begin
        // Valid increasing combination, drawn either from the whole set or
        // from near its top so that exhaustion comes within a few advances.
        if ($urandom_range(0, 1) == 0) begin
          lo = 1;
        end else begin
          lo = n_cfg - keff + 1 - $urandom_range(0, 3);
          if (lo < 1) begin
            lo = 1;
          end
        end
        need = keff;
        pos  = 0;
        for (v = lo; v <= n_cfg && need > 0; v++) begin
          if ($urandom_range(0, n_cfg - v) < need) begin
            send_item(make_load(pos, v));
            pos++;
            need--;
          end
        end
        repeat ($urandom_range(1, 8)) send_item(make_advance());
      end else begin
        repeat ($urandom_range(3, 10)) begin
          if ($urandom_range(0, 2) == 0) begin
            send_item(make_advance());
          end else begin
            send_item(make_load($urandom_range(0, 15), $urandom_range(0, 255)));
          end
        end
      end
    end

    settle_idle();
    repeat (DrainSettle) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("next_lexicographic_combination_tb OK");
    end else begin
      $display("next_lexicographic_combination_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/nlc_pkg.sv
hw/rtl/nlc_ram.sv
hw/rtl/nlc_ctrl.sv
hw/rtl/next_lexicographic_combination.sv
hw/rtl/nlc_checker.sv
verif/next_lexicographic_combination_checker.sv
verif/next_lexicographic_combination_tb.sv
